@@ hdl/sscl_pkg.sv @@
package sscl_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int TIME_BITS_DEF  = 48;

    localparam int CFG_W      = 7;
    localparam int SLICE_W    = 32;
    localparam int ID_W       = 32;
    localparam int OUT_TIME_W = 48;
    localparam int IN_DATA_W  = SLICE_W + OUT_TIME_W;
    localparam int OUT_DATA_W = ID_W + OUT_TIME_W;

    typedef struct packed {
        logic end_seen;
        logic start_seen;
    } label_flags_t;

endpackage

@@ hdl/smoothed_state_change_labeler.sv @@
// smoothed state change labeler
// slices come in on the s_ channel: s_tuser holds the raw off flag, s_tdata the
// slice number and the slice time. each accepted transaction gives exactly one
// result transaction on the m_ channel with the acquisition id, the time since
// the latest acquisition start and the start / end marks in m_tuser.
// cfg_data sets the smoothing window length (0 is taken as 1, values above
// WINDOW_MAX are clamped); a write refills the window with ones. cfg_ready is
// always high; write only while no slice is in flight.
// throughput: one slice per cycle unless the output stalls. the window flags live
// in a one-port-read, one-port-write memory; the read is issued when a slice is
// accepted and the entry is written back when that slice moves to the output
// register, with forwarding when the same entry is read in that cycle (window
// length of one). an accepted slice waits in the first-stage registers, and its
// result is registered into the output register when that stage advances.
// when m_tready is low the output register holds, one more slice is taken into
// the first stage, and then s_tready drops until the output drains.
// reset: window length 1, window all ones, acquisition counter zero, no start
// seen yet; both stages empty.
module smoothed_state_change_labeler #(
    parameter int WINDOW_MAX = sscl_pkg::WINDOW_MAX_DEF,
    parameter int TIME_BITS  = sscl_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sscl_pkg::IN_DATA_W-1:0]  s_tdata,  // slice_number, time_in_run
    input  logic [0:0]                     s_tuser,  // trap_off
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sscl_pkg::OUT_DATA_W-1:0] m_tdata,  // acquisition_id, time_in_acquisition
    output logic [1:0]                     m_tuser,  // start_seen, end_seen
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sscl_pkg::CFG_W-1:0]     cfg_data
);
    import sscl_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam int TW = (TIME_BITS < OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

    logic [LW-1:0]   window_len_reg;
    logic [LW-1:0]   len_clamped;
    logic [CW-1:0]   cfg_wide;
    logic            cfg_write;
    logic [AW-1:0]   head_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   head_next;
    logic [LW:0]     head_inc;
    logic            accept;
    logic            advance;

    logic            s1_valid_reg;
    logic            s1_flag_reg;
    logic [SLICE_W-1:0] s1_slice_reg;
    logic [TW-1:0]   s1_time_reg;
    logic [AW-1:0]   s1_addr_reg;

    logic            old_flag;
    logic [ID_W-1:0] lab_id;
    logic [TW-1:0]   lab_time;
    label_flags_t    lab_flags;

    logic            out_valid_reg;
    logic [ID_W-1:0] out_id_reg;
    logic [TW-1:0]   out_time_reg;
    label_flags_t    out_flags_reg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_wide  = CW'(cfg_data);

    always_comb
    begin
        if (cfg_wide == '0)
        begin
            len_clamped = LW'(1);
        end
        else if (cfg_wide > CW'(WINDOW_MAX))
        begin
            len_clamped = LW'(WINDOW_MAX);
        end
        else
        begin
            len_clamped = LW'(cfg_wide);
        end
    end

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // ring position of the oldest flag
    assign rd_addr   = (LW'(head_reg) >= window_len_reg) ? '0 : head_reg;
    assign head_inc  = (LW + 1)'(rd_addr) + (LW + 1)'(1);
    assign head_next = (head_inc >= (LW + 1)'(window_len_reg)) ? '0 : AW'(head_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= LW'(1);
            head_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                window_len_reg <= len_clamped;
                head_reg       <= '0;
            end
            else if (accept)
            begin
                head_reg <= head_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flag_reg  <= s_tuser[0];
            s1_slice_reg <= s_tdata[SLICE_W-1:0];
            s1_time_reg  <= s_tdata[SLICE_W +: TW];
            s1_addr_reg  <= rd_addr;
        end
        if (advance)
        begin
            out_id_reg    <= lab_id;
            out_time_reg  <= lab_time;
            out_flags_reg <= lab_flags;
        end
    end

    sscl_window_mem #(
        .WINDOW_MAX (WINDOW_MAX),
        .AW         (AW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .refill   (cfg_write),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .wr_en    (advance),
        .wr_addr  (s1_addr_reg),
        .wr_data  (s1_flag_reg),
        .old_flag (old_flag)
    );

    sscl_label #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIME_BITS  (TIME_BITS),
        .LW         (LW),
        .TW         (TW)
    ) u_label (
        .clk                 (clk),
        .rst_n               (rst_n),
        .load_len            (cfg_write),
        .window_len          (cfg_write ? len_clamped : window_len_reg),
        .advance             (advance),
        .flag                (s1_flag_reg),
        .old_flag            (old_flag),
        .slice_number        (s1_slice_reg),
        .time_in_run         (s1_time_reg),
        .acquisition_id      (lab_id),
        .time_in_acquisition (lab_time),
        .flags               (lab_flags)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_TIME_W'(out_time_reg), out_id_reg};
    assign m_tuser  = {out_flags_reg.end_seen, out_flags_reg.start_seen};

endmodule

@@ hdl/sscl_window_mem.sv @@
module sscl_window_mem #(
    parameter int WINDOW_MAX = sscl_pkg::WINDOW_MAX_DEF,
    parameter int AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          refill,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    output logic          old_flag
);
    import sscl_pkg::*;

    logic                  mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid_reg;
    logic                  rd_data_reg;
    logic                  rd_valid_reg;
    logic                  fwd_hit_reg;
    logic                  fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // an entry never written since reset or refill reads as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            fwd_data_reg <= 1'b0;
        end
        else
        begin
            if (refill)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                // write to the same entry in the read cycle is not seen by the array read
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
                fwd_data_reg <= wr_data;
            end
        end
    end

    assign old_flag = fwd_hit_reg  ? fwd_data_reg :
                      rd_valid_reg ? rd_data_reg  : 1'b1;

endmodule

@@ hdl/sscl_label.sv @@
module sscl_label #(
    parameter int WINDOW_MAX = sscl_pkg::WINDOW_MAX_DEF,
    parameter int TIME_BITS  = sscl_pkg::TIME_BITS_DEF,
    parameter int LW         = $clog2(WINDOW_MAX + 1),
    parameter int TW         = (TIME_BITS < sscl_pkg::OUT_TIME_W) ? TIME_BITS
                                                                   : sscl_pkg::OUT_TIME_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_len,
    input  logic [LW-1:0]               window_len,
    input  logic                        advance,
    input  logic                        flag,
    input  logic                        old_flag,
    input  logic [sscl_pkg::SLICE_W-1:0] slice_number,
    input  logic [TW-1:0]               time_in_run,
    output logic [sscl_pkg::ID_W-1:0]   acquisition_id,
    output logic [TW-1:0]               time_in_acquisition,
    output sscl_pkg::label_flags_t      flags
);
    import sscl_pkg::*;

    logic [LW-1:0]   sum_reg;
    logic [LW-1:0]   sum_next;
    logic            prior_smoothed_reg;
    logic [ID_W-1:0] acq_counter_reg;
    logic            have_start_reg;
    logic [TW-1:0]   last_start_reg;
    logic            smoothed;
    logic            edge_hit;
    logic            early;
    logic [TW-1:0]   tacq_old;

    assign sum_next = sum_reg + LW'(flag) - LW'(old_flag);
    // rounded mean without division
    assign smoothed = ({sum_next, 1'b0} >= {1'b0, window_len});
    assign edge_hit = (smoothed != prior_smoothed_reg);
    assign early    = (slice_number <= SLICE_W'(window_len));
    assign tacq_old = (time_in_run >= last_start_reg) ? (time_in_run - last_start_reg) : '0;

    assign flags.start_seen = edge_hit && !flag;
    assign flags.end_seen   = edge_hit && flag;

    always_comb
    begin
        if (flags.start_seen)
        begin
            acquisition_id      = acq_counter_reg + ID_W'(1);
            time_in_acquisition = early ? time_in_run : '0;
        end
        else if (have_start_reg)
        begin
            acquisition_id      = acq_counter_reg;
            time_in_acquisition = tacq_old;
        end
        else
        begin
            acquisition_id      = '0;
            time_in_acquisition = time_in_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg            <= LW'(1);
            prior_smoothed_reg <= 1'b1;
            acq_counter_reg    <= '0;
            have_start_reg     <= 1'b0;
            last_start_reg     <= '0;
        end
        else if (load_len)
        begin
            sum_reg <= window_len;
        end
        else if (advance)
        begin
            sum_reg            <= sum_next;
            prior_smoothed_reg <= smoothed;
            if (flags.start_seen)
            begin
                acq_counter_reg <= acq_counter_reg + ID_W'(1);
                have_start_reg  <= 1'b1;
                last_start_reg  <= early ? '0 : time_in_run;
            end
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import sscl_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 1750 / NUM_PHASES;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        bit [ID_W-1:0]       acq_id;
        bit [OUT_TIME_W-1:0] tacq;
        label_flags_t        marks;
    } slice_label_t;

    typedef struct packed {
        bit                  known;
        bit                  trap_off;
        bit [SLICE_W-1:0]    slice;
        bit [OUT_TIME_W-1:0] t;
        slice_label_t        label;
    } slice_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // slice_number, time_in_run
    logic [0:0]            s_tuser = '0;   // trap_off
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // acquisition_id, time_in_acquisition
    logic [1:0]            m_tuser;        // start_seen, end_seen
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;

    // labeler state as the testbench sees it
    bit [WINDOW_MAX_DEF-1:0] ring;
    int unsigned             ring_head;
    int unsigned             ring_sum;
    int unsigned             win_len;
    bit                      last_smoothed;
    bit [ID_W-1:0]           acq_count;
    bit                      started;
    bit [OUT_TIME_W-1:0]     start_time;

    slice_label_t pending_labels[$];
    slice_row_t   directed_rows[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int pressure_req = 0;
    int pressure_done = 0;
    int hold_left = 0;
    int cycles = 0;
    int label_errors = 0;
    int labels_checked = 0;
    int slices_sent = 0;
    int starts_seen = 0;
    int ends_seen = 0;

    smoothed_state_change_labeler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void set_window(int unsigned v);
        win_len = (v < 1) ? 1 : (v > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : v;
        ring = '1;
        ring_head = 0;
        ring_sum = win_len;
    endfunction

    function automatic void reset_labeler();
        set_window(1);
        last_smoothed = 1'b1;
        acq_count = '0;
        started = 1'b0;
        start_time = '0;
    endfunction

    function automatic slice_label_t label_slice(bit trap_off, bit [SLICE_W-1:0] slice,
                                                 bit [OUT_TIME_W-1:0] t);
        int unsigned  h;
        bit           smoothed;
        slice_label_t lab;
        h = ring_head;
        if (h >= win_len || h >= WINDOW_MAX_DEF)
            h = 0;
        ring_sum = ring_sum - ring[h] + trap_off;
        ring[h] = trap_off;
        h++;
        if (h >= win_len)
            h = 0;
        ring_head = h;
        // rounded mean of the window, halves going up
        smoothed = (2 * ring_sum >= win_len);
        lab.marks = '0;
        if (smoothed != last_smoothed)
        begin
            if (!trap_off)
            begin
                lab.marks.start_seen = 1'b1;
                start_time = (slice <= win_len) ? '0 : t;
                acq_count++;
                started = 1'b1;
            end
            else
                lab.marks.end_seen = 1'b1;
        end
        last_smoothed = smoothed;
        lab.acq_id = started ? acq_count : '0;
        if (!started)
            lab.tacq = t;
        else
            lab.tacq = (t >= start_time) ? t - start_time : '0;
        return lab;
    endfunction

    function automatic void add_row(bit known, bit trap_off, bit [SLICE_W-1:0] slice,
                                    bit [OUT_TIME_W-1:0] t, bit [ID_W-1:0] id,
                                    bit [OUT_TIME_W-1:0] tacq, bit st, bit en);
        slice_row_t r;
        r.known = known;
        r.trap_off = trap_off;
        r.slice = slice;
        r.t = t;
        r.label.acq_id = id;
        r.label.tacq = tacq;
        r.label.marks.start_seen = st;
        r.label.marks.end_seen = en;
        directed_rows = {directed_rows, r};
    endfunction

    task automatic drive_slice(input bit trap_off, input bit [SLICE_W-1:0] slice,
                               input bit [OUT_TIME_W-1:0] t, input bit known,
                               input slice_label_t typed);
        slice_label_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= trap_off;
        s_tdata <= {t, slice};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = label_slice(trap_off, slice, t);
        pending_labels = {pending_labels, (known ? typed : predicted)};
        slices_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_labels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input bit [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_window(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver side: random back-pressure plus one long hold on request
    always @(negedge clk)
    begin
        if (pressure_req != pressure_done)
        begin
            pressure_done = pressure_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        slice_label_t        want;
        logic [ID_W-1:0]       got_id;
        logic [OUT_TIME_W-1:0] got_tacq;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_id = m_tdata[ID_W-1:0];
            got_tacq = m_tdata[OUT_DATA_W-1:ID_W];
            if (pending_labels.size() == 0)
            begin
                $error("result transaction with no slice pending: id %0d time %0d",
                       got_id, got_tacq);
                label_errors++;
            end
            else
            begin
                want = pending_labels.pop_front();
                labels_checked++;
                starts_seen += want.marks.start_seen;
                ends_seen += want.marks.end_seen;
                if (got_id !== want.acq_id)
                begin
                    $error("acquisition_id: expected %0d, got %0d", want.acq_id, got_id);
                    label_errors++;
                end
                if (got_tacq !== want.tacq)
                begin
                    $error("time_in_acquisition: expected %0d, got %0d", want.tacq, got_tacq);
                    label_errors++;
                end
                if (m_tuser[0] !== want.marks.start_seen)
                begin
                    $error("start_seen: expected %0d, got %0d", want.marks.start_seen,
                           m_tuser[0]);
                    label_errors++;
                end
                if (m_tuser[1] !== want.marks.end_seen)
                begin
                    $error("end_seen: expected %0d, got %0d", want.marks.end_seen, m_tuser[1]);
                    label_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        bit [CFG_W-1:0]      window_settings[NUM_PHASES];
        bit [SLICE_W-1:0]    slice_no;
        bit [OUT_TIME_W-1:0] run_time;
        bit [OUT_TIME_W-1:0] t;
        bit [SLICE_W-1:0]    slice;
        bit                  run_flag;
        bit                  flag;
        int                  run_left;
        int                  pick;

        window_settings = '{7'd0, 7'd64, 7'd3, 7'd127, 7'd2, 7'd1, 7'd1, 7'd8, 7'd5};
        window_settings[5] = CFG_W'($urandom_range(1, 64));
        window_settings[8] = CFG_W'($urandom_range(0, 127));

        // reset window of one: every flag change is an edge
        add_row(1, 1, 32'd7, 48'd123, 32'd0, 48'd123, 0, 0);    // no start yet
        add_row(1, 0, 32'd0, 48'd100, 32'd1, 48'd100, 1, 0);    // early start, latched at 0
        add_row(1, 1, 32'd1, 48'd200, 32'd1, 48'd200, 0, 1);
        add_row(1, 1, 32'd2, 48'd300, 32'd1, 48'd300, 0, 0);
        add_row(1, 0, 32'd10, 48'd400, 32'd2, 48'd0, 1, 0);
        add_row(1, 0, 32'd11, 48'd50, 32'd2, 48'd0, 0, 0);      // time behind the start
        add_row(0, 0, '1, '1, '0, '0, 0, 0);
        add_row(1, 1, '1, 48'd0, 32'd2, 48'd0, 0, 1);
        add_row(1, 0, '1, '1, 32'd3, 48'd0, 1, 0);
        add_row(1, 1, 32'd0, '1, 32'd3, 48'd0, 0, 1);
        add_row(1, 0, 32'd1, '1, 32'd4, '1, 1, 0);
        add_row(1, 1, 32'hAAAA_AAAA, 48'h5555_5555_5555, 32'd4, 48'h5555_5555_5555, 0, 1);
        add_row(1, 0, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 32'd5, 48'd0, 1, 0);
        add_row(1, 0, 32'd2, 48'hAAAA_AAAA_AAAB, 32'd5, 48'd1, 0, 0);
        add_row(1, 1, 32'd3, 48'd0, 32'd5, 48'd0, 0, 1);

        reset_labeler();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        snd_idle_pct = 36;
        rcv_idle_pct = 51;
        foreach (directed_rows[i])
            drive_slice(directed_rows[i].trap_off, directed_rows[i].slice, directed_rows[i].t,
                        directed_rows[i].known, directed_rows[i].label);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 3)
            begin
                snd_idle_pct = 36;
                rcv_idle_pct = 51;
            end
            else if (p < 6)
            begin
                snd_idle_pct = 51;
                rcv_idle_pct = 36;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_window(window_settings[p]);
            // long output stall with the input still busy
            if (p == 6)
                pressure_req++;

            slice_no = $urandom_range(0, 2);
            run_time = OUT_TIME_W'($urandom_range(0, 5000));
            run_flag = 1'($urandom_range(0, 1));
            run_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // runs of one flag value, some long enough to swing the window
                if (run_left == 0)
                begin
                    run_flag = ~run_flag;
                    run_left = $urandom_range(1, 2 * win_len + 3);
                end
                run_left--;
                pick = $urandom_range(99);
                flag = (pick < 8) ? 1'($urandom_range(0, 1)) : run_flag;
                slice_no++;
                run_time += OUT_TIME_W'($urandom_range(1, 2000));
                slice = slice_no;
                t = run_time;
                if (pick >= 96)
                begin
                    slice = $urandom;
                    t = OUT_TIME_W'({$urandom, $urandom});
                end
                drive_slice(flag, slice, t, 0, '0);
            end
            wait_idle();
        end

        $display("%0d slices sent, %0d labels checked over %0d window settings",
                 slices_sent, labels_checked, NUM_PHASES + 1);
        $display("%0d acquisition starts and %0d ends labeled", starts_seen, ends_seen);
        if (label_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ smoothed_state_change_labeler.f @@
hdl/sscl_pkg.sv
hdl/sscl_window_mem.sv
hdl/sscl_label.sv
hdl/smoothed_state_change_labeler.sv
bench/tb_top.sv
